FILE: hw/rtl/stscan_pkg.sv
// Shared types, codes and the punctuation lookup for the source token scanner.
package stscan_pkg;

    // Default counter widths
    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int LINE_WIDTH_DEF   = 24;

    localparam int KIND_WIDTH = 4;
    localparam int BYTE_WIDTH = 8;

    // Scan modes
    typedef enum logic [2:0] {
        MODE_TEXT   = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4,
        MODE_QUOTE  = 3'd5,
        MODE_ESCAPE = 3'd6
    } mode_t;

    // Token kinds outside the punctuation range
    localparam logic [KIND_WIDTH-1:0] KIND_COMMENT = 4'd10;
    localparam logic [KIND_WIDTH-1:0] KIND_ERROR   = 4'd11;

    // Character codes
    localparam logic [BYTE_WIDTH-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_WIDTH-1:0] CHAR_STAR      = 8'h2A;
    localparam logic [BYTE_WIDTH-1:0] CHAR_QUOTE     = 8'h22;
    localparam logic [BYTE_WIDTH-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] CHAR_LPAREN    = 8'h28;
    localparam logic [BYTE_WIDTH-1:0] CHAR_RPAREN    = 8'h29;
    localparam logic [BYTE_WIDTH-1:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [BYTE_WIDTH-1:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [BYTE_WIDTH-1:0] CHAR_COMMA     = 8'h2C;
    localparam logic [BYTE_WIDTH-1:0] CHAR_DOT       = 8'h2E;
    localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS     = 8'h2D;
    localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS      = 8'h2B;
    localparam logic [BYTE_WIDTH-1:0] CHAR_SEMI      = 8'h3B;

    // Map a byte to its punctuation kind; anything else maps to the error kind
    function automatic logic [KIND_WIDTH-1:0] punct_kind(input logic [BYTE_WIDTH-1:0] c);
        logic [KIND_WIDTH-1:0] k;
        begin
            case (c)
                CHAR_LPAREN: k = 4'd0;
                CHAR_RPAREN: k = 4'd1;
                CHAR_LBRACE: k = 4'd2;
                CHAR_RBRACE: k = 4'd3;
                CHAR_COMMA:  k = 4'd4;
                CHAR_DOT:    k = 4'd5;
                CHAR_MINUS:  k = 4'd6;
                CHAR_PLUS:   k = 4'd7;
                CHAR_SEMI:   k = 4'd8;
                CHAR_STAR:   k = 4'd9;
                default:     k = KIND_ERROR;
            endcase
            return k;
        end
    endfunction

endpackage

FILE: hw/rtl/source_token_scanner_unit.sv
// Source token scanner: one byte per word in, at most one token word out.
//
// Usage:
//   Input channel (in_valid/in_ready) carries text_byte and first_byte.
//   Set first_byte on the first byte of a new text; it clears the scan
//   mode, byte offset, comment length and line count before that byte.
//   Output channel (out_valid/out_ready) carries token_kind, token_start,
//   token_length, token_line and bad_byte. Bytes that give no token
//   (newlines, string bodies, comment bodies) produce no output word.
// Timing:
//   An input register holds the accepted byte; the combinational scan logic
//   then loads the output register. A token word passes through the input
//   register and then the output register. One byte is taken every cycle
//   unless a byte that gives a token waits on a full output register.
// Reset:
//   rst_n clears the valid flags of both registers and all scan state to plain text at zero.
// Stall:
//   While the output word waits, a byte that gives no token still moves
//   on; a byte that gives a token holds in the input register and input
//   ready drops until the receiver takes the waiting word.
module source_token_scanner_unit #(
    parameter int OFFSET_WIDTH = stscan_pkg::OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = stscan_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH   = stscan_pkg::LINE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [stscan_pkg::BYTE_WIDTH-1:0]     text_byte,
    input  logic                                  first_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [stscan_pkg::KIND_WIDTH-1:0]     token_kind,
    output logic [OFFSET_WIDTH-1:0]               token_start,
    output logic [LENGTH_WIDTH-1:0]               token_length,
    output logic [LINE_WIDTH-1:0]                 token_line,
    output logic [stscan_pkg::BYTE_WIDTH-1:0]     bad_byte
);

    localparam int SUB_W = (OFFSET_WIDTH > LENGTH_WIDTH) ? OFFSET_WIDTH : LENGTH_WIDTH;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

    // Input register
    logic                              in_valid_reg;
    logic [stscan_pkg::BYTE_WIDTH-1:0] byte_reg;
    logic                              first_reg;

    // Scan state
    stscan_pkg::mode_t         mode_reg, mode_next;
    logic [OFFSET_WIDTH-1:0]   offset_reg, offset_next;
    logic [LENGTH_WIDTH-1:0]   length_reg, length_next;
    logic [LINE_WIDTH-1:0]     line_reg, line_next;

    // Output register
    logic                              out_valid_reg;
    logic [stscan_pkg::KIND_WIDTH-1:0] kind_reg;
    logic [OFFSET_WIDTH-1:0]           start_reg;
    logic [LENGTH_WIDTH-1:0]           len_out_reg;
    logic [LINE_WIDTH-1:0]             line_out_reg;
    logic [stscan_pkg::BYTE_WIDTH-1:0] bad_reg;

    // Effective state for the byte in the input register
    stscan_pkg::mode_t         cur_mode;
    logic [OFFSET_WIDTH-1:0]   cur_off;
    logic [LENGTH_WIDTH-1:0]   cur_len;
    logic [LINE_WIDTH-1:0]     cur_row;
    logic [LENGTH_WIDTH-1:0]   len_inc1, len_inc2;
    logic [LINE_WIDTH-1:0]     line_inc;
    logic [SUB_W-1:0]          off_wide, len_wide, start_line_w, start_block_w;

    // Result of the scan logic
    logic                              has_res;
    logic [stscan_pkg::KIND_WIDTH-1:0] res_kind;
    logic [OFFSET_WIDTH-1:0]           res_start;
    logic [LENGTH_WIDTH-1:0]           res_len;
    logic [stscan_pkg::BYTE_WIDTH-1:0] res_bad;

    logic advance, fire;

    // Handshake control
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && (advance || !has_res);
    assign in_ready = !in_valid_reg || fire;

    // Clear state on the first byte of a new text
    always_comb
    begin
        cur_mode = first_reg ? stscan_pkg::MODE_TEXT : mode_reg;
        cur_off  = first_reg ? '0 : offset_reg;
        cur_len  = first_reg ? '0 : length_reg;
        cur_row  = first_reg ? '0 : line_reg;
    end

    // Saturating increments and comment start offsets
    always_comb
    begin
        len_inc1      = (cur_len == LEN_MAX) ? cur_len : cur_len + LENGTH_WIDTH'(1);
        len_inc2      = (cur_len >= LEN_MAX - LENGTH_WIDTH'(1)) ? LEN_MAX
                                                                : cur_len + LENGTH_WIDTH'(2);
        line_inc      = (cur_row == LINE_MAX) ? cur_row : cur_row + LINE_WIDTH'(1);
        off_wide      = SUB_W'(cur_off);
        len_wide      = SUB_W'(cur_len);
        start_line_w  = off_wide - len_wide;
        start_block_w = off_wide - len_wide - SUB_W'(1);
    end

    // Next scan mode
    always_comb
    begin
        mode_next = cur_mode;
        case (cur_mode)
            stscan_pkg::MODE_SLASH:
            begin
                if (byte_reg == stscan_pkg::CHAR_SLASH)
                    mode_next = stscan_pkg::MODE_LINE;
                else if (byte_reg == stscan_pkg::CHAR_STAR)
                    mode_next = stscan_pkg::MODE_BLOCK;
                else
                    mode_next = stscan_pkg::MODE_TEXT;
            end
            stscan_pkg::MODE_LINE:
            begin
                if (byte_reg == stscan_pkg::CHAR_NEWLINE)
                    mode_next = stscan_pkg::MODE_TEXT;
            end
            stscan_pkg::MODE_BLOCK:
            begin
                if (byte_reg == stscan_pkg::CHAR_STAR)
                    mode_next = stscan_pkg::MODE_STAR;
            end
            stscan_pkg::MODE_STAR:
            begin
                if (byte_reg == stscan_pkg::CHAR_SLASH)
                    mode_next = stscan_pkg::MODE_TEXT;
                else if (byte_reg != stscan_pkg::CHAR_STAR)
                    mode_next = stscan_pkg::MODE_BLOCK;
            end
            stscan_pkg::MODE_QUOTE:
            begin
                if (byte_reg == stscan_pkg::CHAR_QUOTE)
                    mode_next = stscan_pkg::MODE_TEXT;
                else if (byte_reg == stscan_pkg::CHAR_BACKSLASH)
                    mode_next = stscan_pkg::MODE_ESCAPE;
            end
            stscan_pkg::MODE_ESCAPE:
            begin
                mode_next = stscan_pkg::MODE_QUOTE;
            end
            default:
            begin
                if (byte_reg == stscan_pkg::CHAR_SLASH)
                    mode_next = stscan_pkg::MODE_SLASH;
                else if (byte_reg == stscan_pkg::CHAR_QUOTE)
                    mode_next = stscan_pkg::MODE_QUOTE;
                else
                    mode_next = stscan_pkg::MODE_TEXT;
            end
        endcase
    end

    // Counters and result word
    always_comb
    begin
        offset_next = cur_off + OFFSET_WIDTH'(1);
        length_next = cur_len;
        line_next   = cur_row;
        has_res     = 1'b0;
        res_kind    = stscan_pkg::KIND_COMMENT;
        res_start   = cur_off;
        res_len     = cur_len;
        res_bad     = '0;
        case (cur_mode)
            stscan_pkg::MODE_SLASH,
            stscan_pkg::MODE_QUOTE,
            stscan_pkg::MODE_ESCAPE:
            begin
                length_next = cur_len;
            end
            stscan_pkg::MODE_LINE:
            begin
                if (byte_reg == stscan_pkg::CHAR_NEWLINE)
                begin
                    has_res     = 1'b1;
                    res_start   = start_line_w[OFFSET_WIDTH-1:0];
                    length_next = '0;
                    line_next   = line_inc;
                end
                else
                    length_next = len_inc1;
            end
            stscan_pkg::MODE_BLOCK:
            begin
                if (byte_reg != stscan_pkg::CHAR_STAR)
                    length_next = len_inc1;
            end
            stscan_pkg::MODE_STAR:
            begin
                if (byte_reg == stscan_pkg::CHAR_SLASH)
                begin
                    has_res     = 1'b1;
                    res_start   = start_block_w[OFFSET_WIDTH-1:0];
                    length_next = '0;
                end
                else if (byte_reg == stscan_pkg::CHAR_STAR)
                    length_next = len_inc1;
                else
                    length_next = len_inc2;
            end
            default:
            begin
                if (byte_reg == stscan_pkg::CHAR_NEWLINE)
                    line_next = line_inc;
                else if (byte_reg != stscan_pkg::CHAR_SLASH &&
                         byte_reg != stscan_pkg::CHAR_QUOTE)
                begin
                    has_res   = 1'b1;
                    res_kind  = stscan_pkg::punct_kind(byte_reg);
                    res_start = cur_off;
                    res_len   = LENGTH_WIDTH'(1);
                    if (res_kind == stscan_pkg::KIND_ERROR)
                        res_bad = byte_reg;
                end
            end
        endcase
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= text_byte;
            first_reg <= first_byte;
        end
    end

    // Advance scan state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stscan_pkg::MODE_TEXT;
            offset_reg <= '0;
            length_reg <= '0;
            line_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            line_reg   <= line_next;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire && has_res;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance && fire && has_res)
        begin
            kind_reg     <= res_kind;
            start_reg    <= res_start;
            len_out_reg  <= res_len;
            line_out_reg <= cur_row;
            bad_reg      <= res_bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_start  = start_reg;
    assign token_length = len_out_reg;
    assign token_line   = line_out_reg;
    assign bad_byte     = bad_reg;

    // Comment length is only held while inside a comment
    a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stscan_pkg::MODE_TEXT || mode_reg == stscan_pkg::MODE_SLASH ||
         mode_reg == stscan_pkg::MODE_QUOTE || mode_reg == stscan_pkg::MODE_ESCAPE)
        |-> length_reg == '0)
        else $error("comment length nonzero outside a comment");

    // Punctuation and error words are one byte long
    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != stscan_pkg::KIND_COMMENT)
        |-> len_out_reg == LENGTH_WIDTH'(1))
        else $error("single-byte token with wrong length");

    // Only error words carry a bad byte
    a_bad_only_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != stscan_pkg::KIND_ERROR) |-> bad_reg == '0)
        else $error("bad byte set on a non-error word");

    // A held byte with an empty output slot always moves on
    a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |-> in_ready)
        else $error("input stalled with empty output register");

    // A consumed byte that makes a word shows it in the next cycle
    a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_res) |=> out_valid_reg)
        else $error("token word lost");

endmodule

FILE: bench/source_token_scanner_checker.sv
// Scoreboard for the source token scanner: tracks scan state and checks every token word.
module source_token_scanner_checker #(
    parameter int OFFSET_WIDTH = stscan_pkg::OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = stscan_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH   = stscan_pkg::LINE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [stscan_pkg::BYTE_WIDTH-1:0]   text_byte,
    input  logic                                first_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [stscan_pkg::KIND_WIDTH-1:0]   token_kind,
    input  logic [OFFSET_WIDTH-1:0]             token_start,
    input  logic [LENGTH_WIDTH-1:0]             token_length,
    input  logic [LINE_WIDTH-1:0]               token_line,
    input  logic [stscan_pkg::BYTE_WIDTH-1:0]   bad_byte,
    output int                                  fail_count,
    output int                                  pending_words
);

    localparam int BYTE_W = stscan_pkg::BYTE_WIDTH;
    localparam int KIND_W = stscan_pkg::KIND_WIDTH;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [OFFSET_WIDTH-1:0] offset;
        logic [LENGTH_WIDTH-1:0] len;
        logic [LINE_WIDTH-1:0]   line_no;
        logic [BYTE_W-1:0]       bad;
    } token_word_t;

    // Punctuation bytes in kind order
    localparam logic [BYTE_W-1:0] PUNCT_CHARS [10] = '{
        stscan_pkg::CHAR_LPAREN, stscan_pkg::CHAR_RPAREN, stscan_pkg::CHAR_LBRACE,
        stscan_pkg::CHAR_RBRACE, stscan_pkg::CHAR_COMMA, stscan_pkg::CHAR_DOT,
        stscan_pkg::CHAR_MINUS, stscan_pkg::CHAR_PLUS, stscan_pkg::CHAR_SEMI,
        stscan_pkg::CHAR_STAR
    };

    stscan_pkg::mode_t       cur_mode;
    logic [OFFSET_WIDTH-1:0] cur_offset;
    logic [LENGTH_WIDTH-1:0] comment_len;
    logic [LINE_WIDTH-1:0]   line_count;
    token_word_t             expected_tokens[$];
    token_word_t             head;

    task automatic clear_scan();
        cur_mode    = stscan_pkg::MODE_TEXT;
        cur_offset  = '0;
        comment_len = '0;
        line_count  = '0;
    endtask

    task automatic bump_comment_len();
        if (comment_len != '1)
            comment_len = comment_len + LENGTH_WIDTH'(1);
    endtask

    task automatic bump_line();
        if (line_count != '1)
            line_count = line_count + LINE_WIDTH'(1);
    endtask

    task automatic queue_token(input logic [KIND_W-1:0] kind,
                               input logic [OFFSET_WIDTH-1:0] offset,
                               input logic [LENGTH_WIDTH-1:0] len,
                               input logic [BYTE_W-1:0] bad);
        token_word_t t;
        t.kind    = kind;
        t.offset  = offset;
        t.len     = len;
        t.line_no = line_count;
        t.bad     = bad;
        expected_tokens.push_back(t);
    endtask

    // Advance the scan state by one byte and queue the token it yields
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic restart);
        int k;
        if (restart)
            clear_scan();
        case (cur_mode)
            stscan_pkg::MODE_SLASH:
            begin
                if (b == stscan_pkg::CHAR_SLASH)
                    cur_mode = stscan_pkg::MODE_LINE;
                else if (b == stscan_pkg::CHAR_STAR)
                    cur_mode = stscan_pkg::MODE_BLOCK;
                else
                    cur_mode = stscan_pkg::MODE_TEXT;
            end
            stscan_pkg::MODE_LINE:
            begin
                if (b == stscan_pkg::CHAR_NEWLINE)
                begin
                    queue_token(stscan_pkg::KIND_COMMENT,
                                cur_offset - OFFSET_WIDTH'(comment_len),
                                comment_len, '0);
                    comment_len = '0;
                    bump_line();
                    cur_mode = stscan_pkg::MODE_TEXT;
                end
                else
                    bump_comment_len();
            end
            stscan_pkg::MODE_BLOCK:
            begin
                if (b == stscan_pkg::CHAR_STAR)
                    cur_mode = stscan_pkg::MODE_STAR;
                else
                    bump_comment_len();
            end
            stscan_pkg::MODE_STAR:
            begin
                if (b == stscan_pkg::CHAR_SLASH)
                begin
                    queue_token(stscan_pkg::KIND_COMMENT,
                                cur_offset - OFFSET_WIDTH'(1) - OFFSET_WIDTH'(comment_len),
                                comment_len, '0);
                    comment_len = '0;
                    cur_mode = stscan_pkg::MODE_TEXT;
                end
                else if (b == stscan_pkg::CHAR_STAR)
                    bump_comment_len();
                else
                begin
                    // the held star and this byte both join the body
                    bump_comment_len();
                    bump_comment_len();
                    cur_mode = stscan_pkg::MODE_BLOCK;
                end
            end
            stscan_pkg::MODE_QUOTE:
            begin
                if (b == stscan_pkg::CHAR_QUOTE)
                    cur_mode = stscan_pkg::MODE_TEXT;
                else if (b == stscan_pkg::CHAR_BACKSLASH)
                    cur_mode = stscan_pkg::MODE_ESCAPE;
            end
            stscan_pkg::MODE_ESCAPE:
                cur_mode = stscan_pkg::MODE_QUOTE;
            default:
            begin
                cur_mode = stscan_pkg::MODE_TEXT;
                if (b == stscan_pkg::CHAR_SLASH)
                    cur_mode = stscan_pkg::MODE_SLASH;
                else if (b == stscan_pkg::CHAR_QUOTE)
                    cur_mode = stscan_pkg::MODE_QUOTE;
                else if (b == stscan_pkg::CHAR_NEWLINE)
                    bump_line();
                else
                begin
                    k = 0;
                    while (k < 10 && PUNCT_CHARS[k] != b)
                        k++;
                    if (k < 10)
                        queue_token(KIND_W'(k), cur_offset, LENGTH_WIDTH'(1), '0);
                    else
                        queue_token(stscan_pkg::KIND_ERROR, cur_offset, LENGTH_WIDTH'(1), b);
                end
            end
        endcase
        cur_offset = cur_offset + OFFSET_WIDTH'(1);
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            fail_count++;
        end
    endtask

    // Predict on accepted bytes, compare accepted token words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            fail_count    = 0;
            pending_words = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                scan_byte(text_byte, first_byte);
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: token word with none expected, actual kind %0d start %0h",
                             $time, token_kind, token_start);
                    fail_count++;
                end
                else
                begin
                    head = expected_tokens.pop_front();
                    check_field("token_kind", 64'(head.kind), 64'(token_kind));
                    check_field("token_start", 64'(head.offset), 64'(token_start));
                    check_field("token_length", 64'(head.len), 64'(token_length));
                    check_field("token_line", 64'(head.line_no), 64'(token_line));
                    check_field("bad_byte", 64'(head.bad), 64'(bad_byte));
                end
            end
            pending_words = expected_tokens.size();
        end
    end

endmodule

FILE: bench/source_token_scanner_unit_tb.sv
// Testbench top for the source token scanner: byte stimulus, receiver stalls and verdict.
module source_token_scanner_unit_tb;

    localparam int BYTE_W       = stscan_pkg::BYTE_WIDTH;
    localparam int ITEM_TARGET  = 1350;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_BODY     = 40;

    localparam logic [BYTE_W-1:0] PUNCT_BYTES [10] = '{
        stscan_pkg::CHAR_LPAREN, stscan_pkg::CHAR_RPAREN, stscan_pkg::CHAR_LBRACE,
        stscan_pkg::CHAR_RBRACE, stscan_pkg::CHAR_COMMA, stscan_pkg::CHAR_DOT,
        stscan_pkg::CHAR_MINUS, stscan_pkg::CHAR_PLUS, stscan_pkg::CHAR_SEMI,
        stscan_pkg::CHAR_STAR
    };

    logic                                    clk        = 1'b0;
    logic                                    rst_n      = 1'b0;
    logic                                    in_valid   = 1'b0;
    logic                                    in_ready;
    logic [BYTE_W-1:0]                       text_byte  = '0;
    logic                                    first_byte = 1'b0;
    logic                                    out_valid;
    logic                                    out_ready  = 1'b0;
    logic [stscan_pkg::KIND_WIDTH-1:0]       token_kind;
    logic [stscan_pkg::OFFSET_WIDTH_DEF-1:0] token_start;
    logic [stscan_pkg::LENGTH_WIDTH_DEF-1:0] token_length;
    logic [stscan_pkg::LINE_WIDTH_DEF-1:0]   token_line;
    logic [BYTE_W-1:0]                       bad_byte;
    int                                      fail_count;
    int                                      pending_words;

    int words_sent   = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    bit gaps_on      = 1'b1;
    bit restart_next = 1'b0;

    source_token_scanner_unit DUT (.*);

    source_token_scanner_checker scoreboard (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: switch stall patterns, hold off for long stretches twice
    initial
    begin : receiver
        int               mode_left;
        int               mode_sel;
        int               phase;
        int               taken;
        int               next_hold;
        logic [7:0]       stall_bits;
        mode_left  = 0;
        mode_sel   = 0;
        phase      = 0;
        taken      = 0;
        next_hold  = 60;
        stall_bits = '1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (rst_n && taken >= next_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                next_hold = (next_hold == 60) ? 500 : 32'h7fff_ffff;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left  = $urandom_range(20, 150);
                    mode_sel   = $urandom_range(0, 3);
                    stall_bits = 8'($urandom_range(1, 255));
                end
                mode_left--;
                phase++;
                case (mode_sel)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= stall_bits[phase % 8];
                endcase
            end
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte_except(
        input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(1, 255));
        while (v == a || v == b);
        return v;
    endfunction

    // Offer one word, with bursts and gaps, and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid     <= 1'b1;
        text_byte    <= value;
        first_byte   <= restart_next;
        restart_next = 1'b0;
        words_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Random source text: mostly well-formed pieces, some noise and cut-off pieces
    task automatic send_random_text();
        int pick;
        int n;
        while (words_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
                restart_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_byte(PUNCT_BYTES[$urandom_range(0, 9)]);
            end
            else if (pick < 38)
                send_byte(stscan_pkg::CHAR_NEWLINE);
            else if (pick < 50)
            begin
                // string with escapes and stray newlines
                send_byte(stscan_pkg::CHAR_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_byte(stscan_pkg::CHAR_BACKSLASH);
                        send_byte(BYTE_W'($urandom_range(1, 255)));
                    end
                    else if ($urandom_range(0, 5) == 0)
                        send_byte(stscan_pkg::CHAR_NEWLINE);
                    else
                        send_byte(rand_byte_except(stscan_pkg::CHAR_QUOTE,
                                                   stscan_pkg::CHAR_BACKSLASH));
                end
                if ($urandom_range(0, 7) == 0)
                    restart_next = 1'b1;
                else
                    send_byte(stscan_pkg::CHAR_QUOTE);
            end
            else if (pick < 62)
            begin
                send_byte(stscan_pkg::CHAR_SLASH);
                send_byte(stscan_pkg::CHAR_SLASH);
                n = $urandom_range(0, 10);
                repeat (n)
                    send_byte(rand_byte_except(stscan_pkg::CHAR_NEWLINE,
                                               stscan_pkg::CHAR_NEWLINE));
                if ($urandom_range(0, 7) == 0)
                    restart_next = 1'b1;
                else
                    send_byte(stscan_pkg::CHAR_NEWLINE);
            end
            else if (pick < 78)
            begin
                // block comment with star groups and newlines in the body
                send_byte(stscan_pkg::CHAR_SLASH);
                send_byte(stscan_pkg::CHAR_STAR);
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat ($urandom_range(1, 2))
                            send_byte(stscan_pkg::CHAR_STAR);
                        send_byte(rand_byte_except(stscan_pkg::CHAR_STAR,
                                                   stscan_pkg::CHAR_SLASH));
                    end
                    else if ($urandom_range(0, 5) == 0)
                        send_byte(stscan_pkg::CHAR_NEWLINE);
                    else
                        send_byte(rand_byte_except(stscan_pkg::CHAR_STAR,
                                                   stscan_pkg::CHAR_STAR));
                end
                if ($urandom_range(0, 7) == 0)
                    restart_next = 1'b1;
                else
                begin
                    repeat ($urandom_range(1, 3))
                        send_byte(stscan_pkg::CHAR_STAR);
                    send_byte(stscan_pkg::CHAR_SLASH);
                end
            end
            else if (pick < 86)
            begin
                send_byte(stscan_pkg::CHAR_SLASH);
                send_byte(rand_byte_except(stscan_pkg::CHAR_SLASH, stscan_pkg::CHAR_STAR));
            end
            else
                send_byte(BYTE_W'($urandom_range(1, 255)));
        end
    endtask

    // Stimulus: directed text, random text, then a back-to-back comment run
    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        restart_next = 1'b1;
        send_text("(){},.-+;*\n");
        send_byte(8'hFF);
        send_text("/x//\n/*\n**/\"\\\"\n\"");

        restart_next = 1'b1;
        send_random_text();

        // block comment and tokens with no gaps on the input
        gaps_on      = 1'b0;
        restart_next = 1'b1;
        send_byte(stscan_pkg::CHAR_SLASH);
        send_byte(stscan_pkg::CHAR_STAR);
        repeat (RUN_BODY)
            send_byte(rand_byte_except(stscan_pkg::CHAR_STAR, stscan_pkg::CHAR_STAR));
        send_byte(stscan_pkg::CHAR_STAR);
        send_byte(stscan_pkg::CHAR_STAR);
        send_byte(stscan_pkg::CHAR_SLASH);
        send_text("(;)-+");
        gaps_on = 1'b1;
        send_text("(;");

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
